/* rtl/core/assert_macros.svh */
// assertion macros used by the checker module of the histogram block
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LHL_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold in the cycle after a condition is seen
`define LHL_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

/* rtl/core/lhl_pkg.sv */
// shared types, codes and helpers of the latency histogram block
// no dependencies; imported by every module of the block
package lhl_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 32;
    localparam int SUM_W    = 64;
    localparam int WIDTH_W  = 16;
    localparam int INDEX_W  = 6;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    // item modes
    localparam logic [MODE_W-1:0] MODE_RECORD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ_LOG  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ_TAIL = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_WIDTH = 2'd2;

    // configuration reset values
    localparam logic [SAMPLE_W-1:0] TAIL_START_RST = 32'd0;
    localparam logic [SAMPLE_W-1:0] TAIL_END_RST   = 32'd64;
    localparam logic [WIDTH_W-1:0]  TAIL_WIDTH_RST = 16'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_READ,
        ST_UPDATE
    } t_state;

    // bin store commands from the sequencer
    typedef struct packed {
        logic log_clr;
        logic log_rd;
        logic log_inc;
        logic tail_clr;
        logic tail_rd;
        logic tail_inc;
    } t_store_ctl;

    // saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

endpackage

/* rtl/core/lhl_div.sv */
// restoring radix-2 divider, one quotient bit per cycle
// depends on lhl_pkg for the operand widths
module lhl_div
    import lhl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SAMPLE_W-1:0] i_dividend,
    input  logic [WIDTH_W-1:0]  i_divisor,
    output logic                o_done,
    output logic [SAMPLE_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(SAMPLE_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_W - 1);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_step;
    logic [SAMPLE_W-1:0] r_quo;
    logic [WIDTH_W-1:0]  r_rem;
    logic [WIDTH_W-1:0]  r_dvs;

    logic [WIDTH_W:0]    w_trial;
    logic [WIDTH_W+1:0]  w_diff;
    logic                w_fits;
    logic [WIDTH_W-1:0]  n_rem;
    logic [SAMPLE_W-1:0] n_quo;

    // shared subtract and compare of one step
    always_comb begin
        w_trial = {r_rem, r_quo[SAMPLE_W-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_dvs};
        w_fits  = !w_diff[WIDTH_W+1];
        n_rem   = w_fits ? w_diff[WIDTH_W-1:0] : w_trial[WIDTH_W-1:0];
        n_quo   = {r_quo[SAMPLE_W-2:0], w_fits};
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operand and partial remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/lhl_store.sv */
// log2 and tail bin count memories with read-modify-write increment
// depends on lhl_pkg for the command struct and the saturating increment
module lhl_store
    import lhl_pkg::*;
#(
    parameter int LOG_BINS       = 32,
    parameter int TAIL_BIN_COUNT = 64,
    parameter int LB_W           = 5,
    parameter int TB_W           = 6
) (
    input  logic             i_clk,
    input  t_store_ctl       i_ctl,
    input  logic [LB_W-1:0]  i_log_addr,
    input  logic [TB_W-1:0]  i_tail_addr,
    output logic [CNT_W-1:0] o_log_rdata,
    output logic [CNT_W-1:0] o_tail_rdata
);

    logic [CNT_W-1:0] r_log_mem  [LOG_BINS];
    logic [CNT_W-1:0] r_tail_mem [TAIL_BIN_COUNT];
    logic [CNT_W-1:0] r_log_rdata;
    logic [CNT_W-1:0] r_tail_rdata;

    // log2 bins: clear, increment of the value read before, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.log_clr) begin
            r_log_mem[i_log_addr] <= '0;
        end else if (i_ctl.log_inc) begin
            r_log_mem[i_log_addr] <= sat_inc(r_log_rdata);
        end
        if (i_ctl.log_rd) begin
            r_log_rdata <= r_log_mem[i_log_addr];
        end
    end

    // tail bins: same scheme
    always_ff @(posedge i_clk) begin
        if (i_ctl.tail_clr) begin
            r_tail_mem[i_tail_addr] <= '0;
        end else if (i_ctl.tail_inc) begin
            r_tail_mem[i_tail_addr] <= sat_inc(r_tail_rdata);
        end
        if (i_ctl.tail_rd) begin
            r_tail_rdata <= r_tail_mem[i_tail_addr];
        end
    end

    assign o_log_rdata  = r_log_rdata;
    assign o_tail_rdata = r_tail_rdata;

endmodule

/* rtl/core/latency_histogram_log2_tail.sv */
// Latency histogram with log2 bins and a linear tail window. A record item
// passes from transfer through a setup state, the bit-serial divider that
// finds the tail bin, a memory read and a write-back that waits for a free
// output register, back to the idle state in which the next transfer is
// taken; the log2 bin is found by a shift counter that runs alongside the
// divider. Read items pass through the registered memory read and the
// write-back only. After reset a clearing pass over max(LOG_BINS,
// TAIL_BIN_COUNT) addresses zeroes the bin memories while the input stays
// stalled. A result waits in an output register, and the next item is taken
// while it waits. Depends on lhl_pkg, lhl_div and lhl_store.
module latency_histogram_log2_tail
    import lhl_pkg::*;
#(
    parameter int LOG_BINS       = 32,
    parameter int TAIL_BIN_COUNT = 64,
    parameter int VALUE_BITS     = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [SAMPLE_W-1:0]  i_sample_value,
    input  logic [INDEX_W-1:0]   i_bin_index,
    // output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [CNT_W-1:0]     o_bin_count,
    output logic [CNT_W-1:0]     o_sample_total,
    output logic [SAMPLE_W-1:0]  o_min_value,
    output logic [SAMPLE_W-1:0]  o_max_value,
    output logic [SUM_W-1:0]     o_value_sum,
    output logic                 o_is_empty
);

    localparam int LB_W      = $clog2(LOG_BINS);
    localparam int TB_W      = (TAIL_BIN_COUNT > 1) ? $clog2(TAIL_BIN_COUNT) : 1;
    localparam int CLR_DEPTH = (LOG_BINS > TAIL_BIN_COUNT) ? LOG_BINS : TAIL_BIN_COUNT;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam logic [SAMPLE_W-1:0] VALUE_MASK = (VALUE_BITS >= SAMPLE_W) ? '1 :
        SAMPLE_W'((64'd1 << VALUE_BITS) - 64'd1);
    localparam logic [LB_W-1:0]  LAST_LOG_BIN = LB_W'(LOG_BINS - 1);
    localparam logic [CLR_W-1:0] LAST_CLR     = CLR_W'(CLR_DEPTH - 1);

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode;
    logic [SAMPLE_W-1:0] r_sample;
    logic [INDEX_W-1:0]  r_index;
    logic [SAMPLE_W-1:0] r_tail_start;
    logic [SAMPLE_W-1:0] r_tail_end;
    logic [WIDTH_W-1:0]  r_tail_width;
    logic [SAMPLE_W-1:0] r_lg_val;
    logic [LB_W-1:0]     r_lg_bin;
    logic                r_tail_hit;
    logic [TB_W-1:0]     r_tail_addr;
    logic [CLR_W-1:0]    r_clr_cnt;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [SAMPLE_W-1:0] r_min, n_min;
    logic [SAMPLE_W-1:0] r_max, n_max;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_bin_count, n_bin_count;

    logic                w_accept;
    logic                w_slot_free;
    logic                w_log_ok;
    logic                w_tail_ok;
    logic                w_in_window;
    logic                w_div_start;
    logic                w_div_done;
    logic [SAMPLE_W-1:0] w_quotient;
    logic [SAMPLE_W-1:0] w_dividend;
    logic [WIDTH_W-1:0]  w_divisor;
    logic                w_update;
    logic [SUM_W:0]      w_sum_ext;
    t_store_ctl          w_ctl;
    logic [LB_W-1:0]     w_log_addr;
    logic [TB_W-1:0]     w_tail_addr;
    logic [CNT_W-1:0]    w_log_rdata;
    logic [CNT_W-1:0]    w_tail_rdata;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_slot_free = !r_out_valid || !i_out_stall;
    assign w_log_ok    = 32'(r_index) < 32'(LOG_BINS);
    assign w_tail_ok   = 32'(r_index) < 32'(TAIL_BIN_COUNT);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_start <= TAIL_START_RST;
            r_tail_end   <= TAIL_END_RST;
            r_tail_width <= TAIL_WIDTH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TAIL_START: r_tail_start <= i_cfg_data;
                CFG_TAIL_END:   r_tail_end   <= i_cfg_data;
                CFG_TAIL_WIDTH: r_tail_width <= i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // tail window test and divider operands
    assign w_in_window = (r_sample >= r_tail_start) && (r_sample < r_tail_end);
    assign w_dividend  = r_sample - r_tail_start;
    assign w_divisor   = (r_tail_width == '0) ? WIDTH_W'(1) : r_tail_width;

    lhl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // store addresses follow the item kind
    always_comb begin
        if (r_state == ST_CLEAR) begin
            w_log_addr  = LB_W'(r_clr_cnt);
            w_tail_addr = TB_W'(r_clr_cnt);
        end else if (r_mode == MODE_RECORD) begin
            w_log_addr  = r_lg_bin;
            w_tail_addr = r_tail_addr;
        end else begin
            w_log_addr  = LB_W'(r_index);
            w_tail_addr = TB_W'(r_index);
        end
    end

    lhl_store #(
        .LOG_BINS       (LOG_BINS),
        .TAIL_BIN_COUNT (TAIL_BIN_COUNT),
        .LB_W           (LB_W),
        .TB_W           (TB_W)
    ) u_store (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_log_addr   (w_log_addr),
        .i_tail_addr  (w_tail_addr),
        .o_log_rdata  (w_log_rdata),
        .o_tail_rdata (w_tail_rdata)
    );

    // statistics after a record
    always_comb begin
        w_sum_ext = {1'b0, r_sum} + (SUM_W + 1)'(r_sample);
        n_sum     = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        n_count   = sat_inc(r_count);
        if (r_count == '0) begin
            n_min = r_sample;
            n_max = r_sample;
        end else begin
            n_min = (r_sample < r_min) ? r_sample : r_min;
            n_max = (r_sample > r_max) ? r_sample : r_max;
        end
    end

    // bin count of a read item
    always_comb begin
        case (r_mode)
            MODE_READ_LOG:  n_bin_count = w_log_ok ? w_log_rdata : '0;
            MODE_READ_TAIL: n_bin_count = w_tail_ok ? w_tail_rdata : '0;
            default:        n_bin_count = '0;
        endcase
    end

    // sequencer: next state and store commands
    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        w_div_start = 1'b0;
        w_update    = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                w_ctl.log_clr  = 32'(r_clr_cnt) < 32'(LOG_BINS);
                w_ctl.tail_clr = 32'(r_clr_cnt) < 32'(TAIL_BIN_COUNT);
                if (r_clr_cnt == LAST_CLR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_mode == MODE_RECORD) ? ST_PREP : ST_READ;
                end
            end
            ST_PREP: begin
                w_div_start = 1'b1;
                n_state     = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_ctl.log_rd  = (r_mode == MODE_RECORD) ||
                                ((r_mode == MODE_READ_LOG) && w_log_ok);
                w_ctl.tail_rd = ((r_mode == MODE_RECORD) && r_tail_hit) ||
                                ((r_mode == MODE_READ_TAIL) && w_tail_ok);
                n_state       = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (w_slot_free) begin
                    w_update       = 1'b1;
                    w_ctl.log_inc  = (r_mode == MODE_RECORD);
                    w_ctl.tail_inc = (r_mode == MODE_RECORD) && r_tail_hit;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_sum       <= '0;
            r_min       <= '0;
            r_max       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end
            if (w_update) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (w_update && (r_mode == MODE_RECORD)) begin
                r_count <= n_count;
                r_sum   <= n_sum;
                r_min   <= n_min;
                r_max   <= n_max;
            end
        end
    end

    // item payload, log2 shift counter and tail bin address
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= i_mode;
            r_sample <= i_sample_value & VALUE_MASK;
            r_index  <= i_bin_index;
        end
        if (r_state == ST_PREP) begin
            r_lg_val   <= r_sample;
            r_lg_bin   <= '0;
            r_tail_hit <= w_in_window;
        end
        if (r_state == ST_DIV) begin
            if ((|r_lg_val[SAMPLE_W-1:1]) && (r_lg_bin != LAST_LOG_BIN)) begin
                r_lg_val <= r_lg_val >> 1;
                r_lg_bin <= r_lg_bin + LB_W'(1);
            end
            if (w_div_done) begin
                r_tail_hit  <= r_tail_hit && (w_quotient < SAMPLE_W'(TAIL_BIN_COUNT));
                r_tail_addr <= TB_W'(w_quotient);
            end
        end
        if (w_update) begin
            r_bin_count <= n_bin_count;
        end
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_bin_count    = r_bin_count;
    assign o_sample_total = r_count;
    assign o_min_value    = r_min;
    assign o_max_value    = r_max;
    assign o_value_sum    = r_sum;
    assign o_is_empty     = (r_count == '0);

endmodule

/* rtl/core/lhl_checker.sv */
// port-level checks of the latency histogram block, bound to the top level
// depends on lhl_pkg and assert_macros.svh
`include "assert_macros.svh"

module lhl_checker
    import lhl_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic [CNT_W-1:0]    o_bin_count,
    input logic [CNT_W-1:0]    o_sample_total,
    input logic [SAMPLE_W-1:0] o_min_value,
    input logic [SAMPLE_W-1:0] o_max_value,
    input logic [SUM_W-1:0]    o_value_sum,
    input logic                o_is_empty
);

    // a held result stays offered
    `LHL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_bin_count), "held result dropped or changed")

    // one item at a time: a transfer closes the input until it is done
    `LHL_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input open right after a transfer")

    // empty histogram reports all statistics as zero
    `LHL_ASSERT(a_empty_zero, i_clk, i_rst_n, !o_is_empty || (o_sample_total == '0 && o_min_value == '0 && o_max_value == '0 && o_value_sum == '0), "empty histogram with nonzero statistics")

    // minimum never above maximum once samples exist
    `LHL_ASSERT(a_min_max, i_clk, i_rst_n, o_is_empty || (o_min_value <= o_max_value), "minimum above maximum")

endmodule

bind latency_histogram_log2_tail lhl_checker u_lhl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_bin_count    (o_bin_count),
    .o_sample_total (o_sample_total),
    .o_min_value    (o_min_value),
    .o_max_value    (o_max_value),
    .o_value_sum    (o_value_sum),
    .o_is_empty     (o_is_empty)
);

/* tb/latency_histogram_log2_tail_tb.sv */
// self-checking testbench for the log2 latency histogram with a tail window
// depends on lhl_pkg and latency_histogram_log2_tail; a queue-fed driver, a
// clocked monitor and an in-bench model of the bins and statistics
module latency_histogram_log2_tail_tb;
    import lhl_pkg::*;

    localparam int LOG_BINS       = 32;
    localparam int TAIL_DEPTH     = 64;
    localparam int ITEMS_PER_SET  = 280;
    localparam int SETTING_COUNT  = 7;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = 60;

    // mode 3 is left unused by the block, register index 3 is unmapped
    localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]  index;
    } hist_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]    bin_count;
        logic [CNT_W-1:0]    sample_total;
        logic [SAMPLE_W-1:0] min_value;
        logic [SAMPLE_W-1:0] max_value;
        logic [SUM_W-1:0]    value_sum;
        logic                is_empty;
    } hist_report_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode = '0;
    logic [SAMPLE_W-1:0]  i_sample_value = '0;
    logic [INDEX_W-1:0]   i_bin_index = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [CNT_W-1:0]     o_bin_count;
    logic [CNT_W-1:0]     o_sample_total;
    logic [SAMPLE_W-1:0]  o_min_value;
    logic [SAMPLE_W-1:0]  o_max_value;
    logic [SUM_W-1:0]     o_value_sum;
    logic                 o_is_empty;

    latency_histogram_log2_tail #(
        .LOG_BINS       (LOG_BINS),
        .TAIL_BIN_COUNT (TAIL_DEPTH),
        .VALUE_BITS     (32)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_sample_value (i_sample_value),
        .i_bin_index    (i_bin_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bin_count    (o_bin_count),
        .o_sample_total (o_sample_total),
        .o_min_value    (o_min_value),
        .o_max_value    (o_max_value),
        .o_value_sum    (o_value_sum),
        .o_is_empty     (o_is_empty)
    );

    always #10 i_clk = ~i_clk;

    // shadow histogram state and tail window registers
    logic [CNT_W-1:0]    log_tally [LOG_BINS];
    logic [CNT_W-1:0]    tail_tally [TAIL_DEPTH];
    logic [CNT_W-1:0]    seen_count = '0;
    logic [SUM_W-1:0]    seen_sum = '0;
    logic [SAMPLE_W-1:0] seen_min = '0;
    logic [SAMPLE_W-1:0] seen_max = '0;
    logic [SAMPLE_W-1:0] win_start = TAIL_START_RST;
    logic [SAMPLE_W-1:0] win_end = TAIL_END_RST;
    logic [WIDTH_W-1:0]  win_width = TAIL_WIDTH_RST;

    hist_item_t   items_to_send [$];
    hist_report_t expected_reports [$];
    int           mismatches = 0;
    int           idle_pct = 0;
    int           stall_pct = 0;
    int           quiet_cycles = 0;
    logic         item_taken = 1'b0;

    initial begin
        foreach (log_tally[i]) log_tally[i] = '0;
        foreach (tail_tally[i]) tail_tally[i] = '0;
    end

    function automatic logic [CNT_W-1:0] bump_count(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // apply one transfer to the shadow histogram and build its report
    function automatic hist_report_t update_histogram(input hist_item_t it);
        hist_report_t        rep;
        logic [SAMPLE_W-1:0] v;
        logic [SAMPLE_W-1:0] shifted;
        logic [SAMPLE_W-1:0] step;
        logic [SAMPLE_W-1:0] slot;
        logic [SUM_W:0]      total;
        int                  lb;
        rep = '0;
        case (it.mode)
            MODE_RECORD: begin
                v = it.sample;
                shifted = v;
                lb = 0;
                while (shifted > 1 && lb + 1 < LOG_BINS) begin
                    shifted = shifted >> 1;
                    lb++;
                end
                log_tally[lb] = bump_count(log_tally[lb]);
                if (seen_count == 0) begin
                    seen_min = v;
                    seen_max = v;
                end else begin
                    if (v < seen_min) seen_min = v;
                    if (v > seen_max) seen_max = v;
                end
                seen_count = bump_count(seen_count);
                total = {1'b0, seen_sum} + {33'd0, v};
                seen_sum = total[SUM_W] ? '1 : total[SUM_W-1:0];
                // tail bin only inside [start, end); zero width acts as one
                if (v >= win_start && v < win_end) begin
                    step = (win_width == 0) ? 32'd1 : {16'd0, win_width};
                    slot = (v - win_start) / step;
                    if (slot < TAIL_DEPTH) tail_tally[slot] = bump_count(tail_tally[slot]);
                end
            end
            MODE_READ_LOG: begin
                if (it.index < LOG_BINS) rep.bin_count = log_tally[it.index];
            end
            MODE_READ_TAIL: begin
                if (it.index < TAIL_DEPTH) rep.bin_count = tail_tally[it.index];
            end
            default: ;
        endcase
        rep.sample_total = seen_count;
        rep.min_value = seen_min;
        rep.max_value = seen_max;
        rep.value_sum = seen_sum;
        rep.is_empty = (seen_count == 0);
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checking, prediction of accepted transfers and watchdog
    always @(posedge i_clk) begin : monitor
        hist_report_t want;
        logic         in_xfer;
        logic         out_xfer;
        in_xfer = i_rst_n && i_in_valid && !o_in_stall;
        out_xfer = i_rst_n && o_out_valid && !i_out_stall;
        if (i_rst_n && i_cfg_we) begin
            case (i_cfg_index)
                CFG_TAIL_START: win_start = i_cfg_data;
                CFG_TAIL_END:   win_end = i_cfg_data;
                CFG_TAIL_WIDTH: win_width = i_cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
        if (out_xfer) begin
            if (expected_reports.size() == 0) begin
                $display("%0t: result with nothing pending, bin_count %0h total %0h",
                         $time, o_bin_count, o_sample_total);
                mismatches++;
            end else begin
                want = expected_reports.pop_front();
                check_field("bin_count", 64'(want.bin_count), 64'(o_bin_count));
                check_field("sample_total", 64'(want.sample_total), 64'(o_sample_total));
                check_field("min_value", 64'(want.min_value), 64'(o_min_value));
                check_field("max_value", 64'(want.max_value), 64'(o_max_value));
                check_field("value_sum", want.value_sum, o_value_sum);
                check_field("is_empty", 64'(want.is_empty), 64'(o_is_empty));
            end
        end
        if (in_xfer) begin
            expected_reports.push_back(update_histogram('{i_mode, i_sample_value, i_bin_index}));
        end
        item_taken <= in_xfer;
        // count cycles without progress while work is outstanding
        if (in_xfer || out_xfer || (items_to_send.size() == 0 && !i_in_valid
                                    && expected_reports.size() == 0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // input driver and output stall generator
    always @(negedge i_clk) begin : driver
        hist_item_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
            if (!i_in_valid || item_taken) begin
                if (items_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    nxt = items_to_send.pop_front();
                    i_in_valid <= 1'b1;
                    i_mode <= nxt.mode;
                    i_sample_value <= nxt.sample;
                    i_bin_index <= nxt.index;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic queue_item(input logic [MODE_W-1:0] mode,
                              input logic [SAMPLE_W-1:0] sample,
                              input logic [INDEX_W-1:0] index);
        items_to_send.push_back('{mode, sample, index});
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        @(posedge i_clk);
        while (items_to_send.size() != 0 || i_in_valid || expected_reports.size() != 0)
            @(posedge i_clk);
    endtask

    // sample biased toward the tail window, its edges and all log2 bins
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] step;
        logic [SAMPLE_W-1:0] span;
        logic [SAMPLE_W-1:0] reach;
        int                  pick;
        step = (win_width == 0) ? 32'd1 : {16'd0, win_width};
        reach = step * TAIL_DEPTH + 8;
        pick = $urandom_range(99);
        if (pick < 35) begin
            span = (win_end > win_start) ? win_end - win_start : 32'd200;
            if (span > reach) span = reach;
            return win_start + $urandom_range(span, 0);
        end else if (pick < 50) begin
            case ($urandom_range(5))
                0: return win_start;
                1: return win_start - 1;
                2: return win_end;
                3: return win_end - 1;
                4: return win_start + step * TAIL_DEPTH - 1;
                default: return win_start + step * TAIL_DEPTH;
            endcase
        end else if (pick < 85) begin
            return $urandom >> $urandom_range(31);
        end
        return $urandom;
    endfunction

    task automatic queue_random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55)
            queue_item(MODE_RECORD, pick_sample(), INDEX_W'($urandom_range(63)));
        else if (pick < 75)
            queue_item(MODE_READ_LOG, $urandom, INDEX_W'($urandom_range(39)));
        else if (pick < 95)
            queue_item(MODE_READ_TAIL, $urandom, INDEX_W'($urandom_range(63)));
        else
            queue_item(MODE_UNUSED, $urandom, INDEX_W'($urandom_range(63)));
    endtask

    // tail window settings, from the reset one through the extremes
    task automatic apply_setting(input int setting);
        case (setting)
            1: begin
                // bins past the last one are dropped from 4200 upward
                write_reg(CFG_TAIL_START, 32'd1000);
                write_reg(CFG_TAIL_END, 32'd5000);
                write_reg(CFG_TAIL_WIDTH, 32'd50);
            end
            2: begin
                write_reg(CFG_TAIL_START, 32'd0);
                write_reg(CFG_TAIL_END, 32'hFFFF_FFFF);
                write_reg(CFG_TAIL_WIDTH, 32'd65535);
            end
            3: begin
                // inverted window, zero width
                write_reg(CFG_TAIL_START, 32'd5000);
                write_reg(CFG_TAIL_END, 32'd100);
                write_reg(CFG_TAIL_WIDTH, 32'd0);
            end
            4: begin
                // window at the top of the range, width with junk upper bits
                write_reg(CFG_TAIL_START, 32'hFFFF_FFC0);
                write_reg(CFG_TAIL_END, 32'hFFFF_FFFF);
                write_reg(CFG_TAIL_WIDTH, 32'hFFFF_0000);
                write_reg(CFG_SPARE, $urandom);
            end
            5: begin
                write_reg(CFG_TAIL_START, 32'hFFFF_FFFF);
                write_reg(CFG_TAIL_END, 32'd0);
                write_reg(CFG_TAIL_WIDTH, 32'd7);
            end
            default: begin
                write_reg(CFG_TAIL_START, 32'd16);
                write_reg(CFG_TAIL_END, 32'd400);
                write_reg(CFG_TAIL_WIDTH, 32'd6);
            end
        endcase
    endtask

    initial begin : stimulus
        int setting;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty histogram: reads, out-of-range log bin, unused mode
        queue_item(MODE_READ_LOG, 32'd0, 6'd0);
        queue_item(MODE_READ_TAIL, 32'd0, 6'd0);
        queue_item(MODE_UNUSED, 32'hFFFF_FFFF, 6'd63);
        queue_item(MODE_READ_LOG, 32'd0, 6'd63);
        // extremes of the sample and the reset tail window edges
        queue_item(MODE_RECORD, 32'd0, 6'd0);
        queue_item(MODE_RECORD, 32'd1, 6'd63);
        queue_item(MODE_RECORD, 32'd2, 6'd0);
        queue_item(MODE_RECORD, 32'd3, 6'd0);
        queue_item(MODE_RECORD, 32'hFFFF_FFFF, 6'd0);
        queue_item(MODE_RECORD, 32'h8000_0000, 6'd0);
        queue_item(MODE_RECORD, 32'd63, 6'd0);
        queue_item(MODE_RECORD, 32'd64, 6'd0);
        queue_item(MODE_RECORD, 32'd5, 6'd0);
        queue_item(MODE_RECORD, 32'h7FFF_FFFF, 6'd0);
        queue_item(MODE_READ_LOG, 32'd0, 6'd0);
        queue_item(MODE_READ_LOG, 32'd0, 6'd1);
        queue_item(MODE_READ_LOG, 32'hFFFF_FFFF, 6'd31);
        queue_item(MODE_READ_LOG, 32'd0, 6'd32);
        queue_item(MODE_READ_TAIL, 32'd0, 6'd0);
        queue_item(MODE_READ_TAIL, 32'd0, 6'd63);
        queue_item(MODE_READ_TAIL, 32'd0, 6'd5);
        queue_item(MODE_UNUSED, 32'hFFFF_FFFF, 6'd63);

        for (setting = 0; setting < SETTING_COUNT; setting++) begin
            if (setting > 0) begin
                wait_drained();
                apply_setting(setting);
            end
            // rotate: no idling, sender idle, receiver stalling, both
            case (setting % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            repeat (ITEMS_PER_SET) queue_random_item();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
